[sv/onset_peak_picker_unit_assert.svh]
// Assertion macros for the onset peak picker.
// Expects clk and rst_n in the scope of each use.
`ifndef ONSET_PEAK_PICKER_UNIT_ASSERT_SVH
`define ONSET_PEAK_PICKER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define OPP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define OPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/opp_pkg.sv]
// Shared constants, register indexes, controller states and command/status types
// for the onset peak picker. No dependencies.
`default_nettype none

package opp_pkg;

    parameter int OPP_MAX_WINDOW    = 32;
    parameter int OPP_HISTORY_DEPTH = 128;
    parameter int OPP_SAMPLE_WIDTH  = 16;
    parameter int OPP_INDEX_WIDTH   = 20;

    parameter int CFG_INDEX_WIDTH = 3;
    parameter int CFG_DATA_WIDTH  = 16;
    parameter int WIN_CFG_WIDTH   = 6;
    parameter int OFFSET_WIDTH    = 16;
    parameter int GAP_WIDTH       = 16;
    parameter int STEP_CNT_WIDTH  = 6;

    parameter logic [STEP_CNT_WIDTH-1:0] STEP_CAP = 6'd33;

    parameter logic [WIN_CFG_WIDTH-1:0] RST_MAX_BEFORE = 6'd3;
    parameter logic [WIN_CFG_WIDTH-1:0] RST_MAX_AFTER  = 6'd3;
    parameter logic [WIN_CFG_WIDTH-1:0] RST_AVG_BEFORE = 6'd3;
    parameter logic [WIN_CFG_WIDTH-1:0] RST_AVG_AFTER  = 6'd5;
    parameter logic [OFFSET_WIDTH-1:0]  RST_THRESHOLD  = 16'd0;
    parameter logic [GAP_WIDTH-1:0]     RST_MIN_GAP    = 16'd10;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MAX_BEFORE = 3'd0,
        REG_MAX_AFTER  = 3'd1,
        REG_AVG_BEFORE = 3'd2,
        REG_AVG_AFTER  = 3'd3,
        REG_THRESHOLD  = 3'd4,
        REG_MIN_GAP    = 3'd5
    } opp_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ_X,
        ST_LOAD_X,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_DECIDE,
        ST_EMIT,
        ST_FLUSH,
        ST_MARK
    } opp_state_t;

    typedef struct packed {
        logic accept;
        logic read_x;
        logic load_x;
        logic scan;
        logic mul;
        logic advance;
        logic store_held;
        logic push_held;
        logic push_last;
        logic mark;
    } opp_cmd_t;

    typedef struct packed {
        logic due;
        logic eos;
        logic scan_last;
        logic pick;
        logic held_valid;
        logic out_free;
    } opp_status_t;

endpackage

`default_nettype wire

[sv/opp_stream_if.sv]
// Valid/ready stream interfaces for the onset peak picker input and result words.
// No dependencies.
`default_nettype none

interface opp_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           end_of_stream;

    modport source (output valid, output sample, output end_of_stream, input ready);
    modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface opp_out_if #(
    parameter int INDEX_WIDTH = 20
);
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] peak_index;
    logic                   is_peak;
    logic                   run_last;

    modport source (output valid, output peak_index, output is_peak, output run_last,
                    input ready);
    modport sink   (input valid, input peak_index, input is_peak, input run_last,
                    output ready);
endinterface

`default_nettype wire

[sv/opp_ctrl.sv]
// Sequencing state machine of the onset peak picker.
// Depends on opp_pkg; drives opp_datapath through opp_cmd_t.
`default_nettype none

module opp_ctrl
    import opp_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  opp_status_t status,
    output opp_cmd_t    cmd
);

    opp_state_t state_reg;
    opp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.due)
                begin
                    state_next = ST_READ_X;
                end
                else if (status.eos)
                begin
                    state_next = ST_MARK;
                end
                else if (status.held_valid)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ_X: state_next = ST_LOAD_X;
            ST_LOAD_X: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_MUL;
            ST_MUL:    state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                state_next = status.pick ? ST_EMIT : ST_CHECK;
            end
            ST_EMIT:
            begin
                if (!status.held_valid || status.out_free)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MARK:
            begin
                if (status.out_free && !status.held_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_READ_X: cmd.read_x = 1'b1;
            ST_LOAD_X: cmd.load_x = 1'b1;
            ST_SCAN:   cmd.scan   = 1'b1;
            ST_MUL:    cmd.mul    = 1'b1;
            ST_DECIDE:
            begin
                cmd.advance = !status.pick;
            end
            ST_EMIT:
            begin
                if (!status.held_valid || status.out_free)
                begin
                    cmd.store_held = 1'b1;
                    cmd.advance    = 1'b1;
                    cmd.push_held  = status.held_valid;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.push_held = 1'b1;
                    cmd.push_last = 1'b1;
                end
            end
            ST_MARK:
            begin
                if (status.out_free)
                begin
                    cmd.push_held = status.held_valid;
                    cmd.mark      = !status.held_valid;
                end
            end
            default:
            begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/opp_datapath.sv]
// History memory, window scan, mean test, counters and result registers.
// Depends on opp_pkg and onset_peak_picker_unit_assert.svh; steered by opp_ctrl.
`default_nettype none
`include "onset_peak_picker_unit_assert.svh"

module opp_datapath
    import opp_pkg::*;
#(
    parameter int MAX_WINDOW    = OPP_MAX_WINDOW,
    parameter int HISTORY_DEPTH = OPP_HISTORY_DEPTH,
    parameter int SAMPLE_WIDTH  = OPP_SAMPLE_WIDTH,
    parameter int INDEX_WIDTH   = OPP_INDEX_WIDTH
)
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_write,
    input  wire  [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire  [CFG_DATA_WIDTH-1:0]      cfg_data,
    input  wire  signed [SAMPLE_WIDTH-1:0] in_sample,
    input  wire                            in_eos,
    input  opp_cmd_t                       cmd,
    output opp_status_t                    status,
    input  wire                            out_ready,
    output logic                           out_valid,
    output logic [INDEX_WIDTH-1:0]         out_index,
    output logic                           out_is_peak,
    output logic                           out_last
);

    localparam int WW   = $clog2(MAX_WINDOW + 1);
    localparam int OW   = WW + 1;
    localparam int CW   = $clog2(2 * MAX_WINDOW + 1);
    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int SUMW = SAMPLE_WIDTH + CW;
    localparam int PW   = ((SAMPLE_WIDTH > OFFSET_WIDTH) ? SAMPLE_WIDTH : OFFSET_WIDTH) + CW + 2;
    localparam int GW   = GAP_WIDTH + 1;

    localparam logic [WW-1:0] WinMax  = WW'(MAX_WINDOW);
    localparam logic [AW-1:0] AddrTop = AW'(HISTORY_DEPTH - 1);

    // configuration
    logic [WIN_CFG_WIDTH-1:0] max_before_reg;
    logic [WIN_CFG_WIDTH-1:0] max_after_reg;
    logic [WIN_CFG_WIDTH-1:0] avg_before_reg;
    logic [WIN_CFG_WIDTH-1:0] avg_after_reg;
    logic [OFFSET_WIDTH-1:0]  threshold_reg;
    logic [GAP_WIDTH-1:0]     min_gap_reg;

    // stream state
    logic [INDEX_WIDTH-1:0]    count_reg;
    logic [INDEX_WIDTH-1:0]    decided_reg;
    logic [WW-1:0]             depth_reg;
    logic [AW-1:0]             wr_addr_reg;
    logic [AW-1:0]             i_addr_reg;
    logic                      eos_reg;
    logic                      peak_seen_reg;
    logic [GW-1:0]             dist_reg;
    logic [STEP_CNT_WIDTH-1:0] step_cnt_reg;

    // scan
    logic signed [SAMPLE_WIDTH-1:0] hist_mem [HISTORY_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]                  rd_addr;
    logic [WW-1:0]                  pre_m_reg;
    logic [WW-1:0]                  pre_a_reg;
    logic [WW-1:0]                  post_m_reg;
    logic [WW-1:0]                  post_a_reg;
    logic [WW-1:0]                  hi_end_reg;
    logic signed [OW-1:0]           off_reg;
    logic [AW-1:0]                  scan_addr_reg;
    logic                           d1_valid_reg;
    logic                           d1_max_reg;
    logic                           d1_avg_reg;
    logic signed [SAMPLE_WIDTH-1:0] xi_reg;
    logic                           max_fail_reg;
    logic signed [SUMW-1:0]         sum_reg;
    logic [CW-1:0]                  cnt_reg;
    logic signed [PW-1:0]           lhs_reg;
    logic signed [PW-1:0]           rhs_reg;

    // results
    logic                   held_valid_reg;
    logic [INDEX_WIDTH-1:0] held_index_reg;
    logic                   out_valid_reg;
    logic [INDEX_WIDTH-1:0] out_index_reg;
    logic                   out_peak_reg;
    logic                   out_last_reg;

    logic [WW-1:0]          win_pre_m;
    logic [WW-1:0]          win_pre_a;
    logic [WW-1:0]          win_post_m;
    logic [WW-1:0]          win_post_a;
    logic [WW-1:0]          win_post;
    logic [INDEX_WIDTH-1:0] pending;
    logic [WW-1:0]          pending_clip;
    logic [WW-1:0]          pre_m_c;
    logic [WW-1:0]          pre_a_c;
    logic [WW-1:0]          post_m_c;
    logic [WW-1:0]          post_a_c;
    logic [WW-1:0]          lo_off;
    logic [AW:0]            start_sum;
    logic [AW-1:0]          start_addr;
    logic                   cur_in_max;
    logic                   cur_in_avg;
    logic                   gap_ok;
    logic                   pick;
    logic                   out_free;
    logic                   out_load;

    function automatic logic [WW-1:0] clip_before(input logic [WIN_CFG_WIDTH-1:0] v);
        if (32'(v) > MAX_WINDOW)
        begin
            return WW'(MAX_WINDOW);
        end
        return WW'(v);
    endfunction

    function automatic logic [WW-1:0] clip_after(input logic [WIN_CFG_WIDTH-1:0] v);
        if (v == '0)
        begin
            return WW'(1);
        end
        return clip_before(v);
    endfunction

    function automatic logic [WW-1:0] min_w(input logic [WW-1:0] a, input logic [WW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [WW-1:0] max_w(input logic [WW-1:0] a, input logic [WW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == AddrTop) ? '0 : a + AW'(1);
    endfunction

    always_comb
    begin
        win_pre_m    = clip_before(max_before_reg);
        win_pre_a    = clip_before(avg_before_reg);
        win_post_m   = clip_after(max_after_reg);
        win_post_a   = clip_after(avg_after_reg);
        win_post     = max_w(win_post_m, win_post_a);
        pending      = count_reg - decided_reg;
        pending_clip = (pending > INDEX_WIDTH'(MAX_WINDOW)) ? WinMax : WW'(pending);
        pre_m_c      = min_w(win_pre_m, depth_reg);
        pre_a_c      = min_w(win_pre_a, depth_reg);
        post_m_c     = min_w(win_post_m, pending_clip);
        post_a_c     = min_w(win_post_a, pending_clip);
        lo_off       = max_w(pre_m_c, pre_a_c);
        start_sum    = (AW + 1)'(i_addr_reg) + (AW + 1)'(HISTORY_DEPTH) - (AW + 1)'(lo_off);
        start_addr   = (start_sum >= (AW + 1)'(HISTORY_DEPTH)) ?
                       AW'(start_sum - (AW + 1)'(HISTORY_DEPTH)) : AW'(start_sum);
    end

    always_comb
    begin
        cur_in_max = (off_reg >= -$signed({1'b0, pre_m_reg}))
                  && (off_reg < $signed({1'b0, post_m_reg}));
        cur_in_avg = (off_reg >= -$signed({1'b0, pre_a_reg}))
                  && (off_reg < $signed({1'b0, post_a_reg}));
        gap_ok     = !peak_seen_reg || (dist_reg > {1'b0, min_gap_reg});
        pick       = !max_fail_reg && (lhs_reg >= rhs_reg) && gap_ok;
        out_free   = !out_valid_reg || out_ready;
        out_load   = cmd.push_held || cmd.mark;
        rd_addr    = cmd.read_x ? i_addr_reg : scan_addr_reg;
    end

    always_comb
    begin
        status.due        = (pending != '0) && (step_cnt_reg < STEP_CAP)
                         && (eos_reg || (pending >= {{(INDEX_WIDTH - WW){1'b0}}, win_post}));
        status.eos        = eos_reg;
        status.scan_last  = (off_reg == ($signed({1'b0, hi_end_reg}) - OW'(1)));
        status.pick       = pick;
        status.held_valid = held_valid_reg;
        status.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_before_reg <= RST_MAX_BEFORE;
            max_after_reg  <= RST_MAX_AFTER;
            avg_before_reg <= RST_AVG_BEFORE;
            avg_after_reg  <= RST_AVG_AFTER;
            threshold_reg  <= RST_THRESHOLD;
            min_gap_reg    <= RST_MIN_GAP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_BEFORE: max_before_reg <= cfg_data[WIN_CFG_WIDTH-1:0];
                REG_MAX_AFTER:  max_after_reg  <= cfg_data[WIN_CFG_WIDTH-1:0];
                REG_AVG_BEFORE: avg_before_reg <= cfg_data[WIN_CFG_WIDTH-1:0];
                REG_AVG_AFTER:  avg_after_reg  <= cfg_data[WIN_CFG_WIDTH-1:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data[OFFSET_WIDTH-1:0];
                REG_MIN_GAP:    min_gap_reg    <= cfg_data[GAP_WIDTH-1:0];
                default:        min_gap_reg    <= min_gap_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hist_mem[wr_addr_reg] <= in_sample;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            decided_reg   <= '0;
            depth_reg     <= '0;
            wr_addr_reg   <= '0;
            i_addr_reg    <= '0;
            eos_reg       <= 1'b0;
            peak_seen_reg <= 1'b0;
            dist_reg      <= '0;
            step_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                count_reg    <= count_reg + INDEX_WIDTH'(1);
                wr_addr_reg  <= addr_inc(wr_addr_reg);
                eos_reg      <= in_eos;
                step_cnt_reg <= '0;
            end
            if (cmd.advance)
            begin
                decided_reg  <= decided_reg + INDEX_WIDTH'(1);
                i_addr_reg   <= addr_inc(i_addr_reg);
                step_cnt_reg <= step_cnt_reg + STEP_CNT_WIDTH'(1);
                if (depth_reg != WinMax)
                begin
                    depth_reg <= depth_reg + WW'(1);
                end
                if (pick)
                begin
                    peak_seen_reg <= 1'b1;
                    dist_reg      <= GW'(1);
                end
                else if (dist_reg != '1)
                begin
                    dist_reg <= dist_reg + GW'(1);
                end
            end
            if (cmd.mark)
            begin
                count_reg     <= '0;
                decided_reg   <= '0;
                depth_reg     <= '0;
                wr_addr_reg   <= '0;
                i_addr_reg    <= '0;
                eos_reg       <= 1'b0;
                peak_seen_reg <= 1'b0;
                dist_reg      <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
        end
        else
        begin
            d1_valid_reg <= cmd.scan;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_x)
        begin
            pre_m_reg     <= pre_m_c;
            pre_a_reg     <= pre_a_c;
            post_m_reg    <= post_m_c;
            post_a_reg    <= post_a_c;
            hi_end_reg    <= max_w(post_m_c, post_a_c);
            off_reg       <= -$signed({1'b0, lo_off});
            scan_addr_reg <= start_addr;
        end
        if (cmd.scan)
        begin
            off_reg       <= off_reg + OW'(1);
            scan_addr_reg <= addr_inc(scan_addr_reg);
            d1_max_reg    <= cur_in_max;
            d1_avg_reg    <= cur_in_avg;
        end
        if (cmd.load_x)
        begin
            xi_reg       <= rd_data_reg;
            max_fail_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
        end
        else if (d1_valid_reg)
        begin
            if (d1_max_reg && (rd_data_reg > xi_reg))
            begin
                max_fail_reg <= 1'b1;
            end
            if (d1_avg_reg)
            begin
                sum_reg <= sum_reg + SUMW'(rd_data_reg);
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
        if (cmd.mul)
        begin
            lhs_reg <= PW'($signed(xi_reg) * $signed({1'b0, cnt_reg}));
            rhs_reg <= PW'(sum_reg)
                     + PW'($signed(threshold_reg) * $signed({1'b0, cnt_reg}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.store_held)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (cmd.push_held)
            begin
                held_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_held)
        begin
            held_index_reg <= decided_reg;
        end
        if (cmd.push_held)
        begin
            out_index_reg <= held_index_reg;
            out_peak_reg  <= 1'b1;
            out_last_reg  <= cmd.push_last;
        end
        else if (cmd.mark)
        begin
            out_index_reg <= count_reg;
            out_peak_reg  <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_index   = out_index_reg;
    assign out_is_peak = out_peak_reg;
    assign out_last    = out_last_reg;

    `OPP_ASSERT_SAME(a_advance_pending, cmd.advance, pending != '0,
        "decision taken with no pending sample")
    `OPP_ASSERT_SAME(a_load_when_free, out_load, out_free,
        "result register overwritten before it was taken")
    `OPP_ASSERT_SAME(a_mark_after_held, cmd.mark, !held_valid_reg,
        "end marker sent ahead of a held peak")
    `OPP_ASSERT_NEXT(a_mark_clears, cmd.mark,
        (count_reg == '0) && (decided_reg == '0) && !peak_seen_reg,
        "stream state not cleared after end marker")

endmodule

`default_nettype wire

[sv/onset_peak_picker_unit.sv]
// Onset peak picker top level: opp_ctrl sequencer plus opp_datapath, joined by command/status.
// Per decision: check, read, load, a scan step per sample of the span (up to 2*MAX_WINDOW),
// drain, multiply, decide and, with a peak, emit; an item is accepted in idle before its
// decisions, plus a flush step for a held peak and a mark step for an end marker; stalls add waits.
// Result register sits between core and output; a new item is taken while it waits.
// rst_n clears all control state at once; the history memory is not cleared.
`default_nettype none

module onset_peak_picker_unit
    import opp_pkg::*;
#(
    parameter int MAX_WINDOW    = OPP_MAX_WINDOW,
    parameter int HISTORY_DEPTH = OPP_HISTORY_DEPTH,
    parameter int SAMPLE_WIDTH  = OPP_SAMPLE_WIDTH,
    parameter int INDEX_WIDTH   = OPP_INDEX_WIDTH
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_write,
    input  wire  [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire  [CFG_DATA_WIDTH-1:0]  cfg_data,
    opp_in_if.sink                     in_ch,
    opp_out_if.source                  out_ch
);

    opp_cmd_t    cmd;
    opp_status_t status;
    logic        in_ready;

    opp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    opp_datapath #(
        .MAX_WINDOW    (MAX_WINDOW),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .INDEX_WIDTH   (INDEX_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_sample   (in_ch.sample),
        .in_eos      (in_ch.end_of_stream),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_index   (out_ch.peak_index),
        .out_is_peak (out_ch.is_peak),
        .out_last    (out_ch.run_last)
    );

    assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

[verif/opp_peak_checker.sv]
// Peak picker scoreboard: mirrors register writes, predicts peak and end words
// from accepted samples and compares them with the result channel.
// Depends on opp_pkg and the opp_in_if / opp_out_if interfaces.
module opp_peak_checker
    import opp_pkg::*;
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_write,
    input  wire [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire [CFG_DATA_WIDTH-1:0]  cfg_data,
    opp_in_if                         in_ch,
    opp_out_if                        out_ch,
    output int                        mismatches,
    output int                        waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OPP_INDEX_WIDTH-1:0] index;
        logic                       is_peak;
        logic                       run_last;
    } peak_word_t;

    peak_word_t                   expected_q[$];
    logic signed [OPP_SAMPLE_WIDTH-1:0] envelope[OPP_HISTORY_DEPTH];
    int unsigned                  stream_len;
    int unsigned                  decided;
    int unsigned                  prior_peak;
    bit                           peak_seen;
    int                           fail_count;

    logic [WIN_CFG_WIDTH-1:0]       max_before;
    logic [WIN_CFG_WIDTH-1:0]       max_after;
    logic [WIN_CFG_WIDTH-1:0]       avg_before;
    logic [WIN_CFG_WIDTH-1:0]       avg_after;
    logic signed [OFFSET_WIDTH-1:0] offset;
    logic [GAP_WIDTH-1:0]           min_gap;

    function automatic int unsigned span_before(logic [WIN_CFG_WIDTH-1:0] v);
        return (v > OPP_MAX_WINDOW) ? OPP_MAX_WINDOW : int'(v);
    endfunction

    function automatic int unsigned span_after(logic [WIN_CFG_WIDTH-1:0] v);
        if (v == 0)
            return 1;
        return (v > OPP_MAX_WINDOW) ? OPP_MAX_WINDOW : int'(v);
    endfunction

    function automatic bit is_onset(int unsigned i, int unsigned n);
        int unsigned lo;
        int unsigned hi;
        longint      xi;
        longint      total;
        longint      cnt;
        xi = envelope[i % OPP_HISTORY_DEPTH];
        lo = (i >= span_before(max_before)) ? i - span_before(max_before) : 0;
        hi = i + span_after(max_after) - 1;
        if (hi > n - 1)
            hi = n - 1;
        for (int unsigned k = lo; k <= hi; k++)
            if (envelope[k % OPP_HISTORY_DEPTH] > xi)
                return 1'b0;
        lo = (i >= span_before(avg_before)) ? i - span_before(avg_before) : 0;
        hi = i + span_after(avg_after) - 1;
        if (hi > n - 1)
            hi = n - 1;
        total = 0;
        for (int unsigned k = lo; k <= hi; k++)
            total += envelope[k % OPP_HISTORY_DEPTH];
        cnt = hi - lo + 1;
        if (xi * cnt < total + longint'(offset) * cnt)
            return 1'b0;
        if (peak_seen && (i - prior_peak) <= min_gap)
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic take_sample(logic signed [OPP_SAMPLE_WIDTH-1:0] s, logic eos);
        int unsigned post;
        int          first;
        peak_word_t  w;
        post = span_after(max_after);
        if (span_after(avg_after) > post)
            post = span_after(avg_after);
        envelope[stream_len % OPP_HISTORY_DEPTH] = s;
        stream_len++;
        first = expected_q.size();
        while (decided < stream_len) begin
            if (!eos && decided + post > stream_len)
                break;
            if (is_onset(decided, stream_len)) begin
                w.index    = decided[OPP_INDEX_WIDTH-1:0];
                w.is_peak  = 1'b1;
                w.run_last = 1'b0;
                expected_q.insert(expected_q.size(), w);
                prior_peak = decided;
                peak_seen  = 1'b1;
            end
            decided++;
        end
        if (eos) begin
            w.index    = stream_len[OPP_INDEX_WIDTH-1:0];
            w.is_peak  = 1'b0;
            w.run_last = 1'b0;
            expected_q.insert(expected_q.size(), w);
            stream_len = 0;
            decided    = 0;
            prior_peak = 0;
            peak_seen  = 1'b0;
        end
        if (expected_q.size() > first) begin
            w = expected_q[expected_q.size() - 1];
            w.run_last = 1'b1;
            expected_q[expected_q.size() - 1] = w;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        peak_word_t got;
        peak_word_t want;
        if (!rst_n) begin
            expected_q.delete();
            stream_len = 0;
            decided    = 0;
            prior_peak = 0;
            peak_seen  = 1'b0;
            fail_count = 0;
            max_before = RST_MAX_BEFORE;
            max_after  = RST_MAX_AFTER;
            avg_before = RST_AVG_BEFORE;
            avg_after  = RST_AVG_AFTER;
            offset     = RST_THRESHOLD;
            min_gap    = RST_MIN_GAP;
            mismatches <= 0;
            waiting    <= 0;
        end
        else begin
            if (cfg_write) begin
                case (opp_reg_t'(cfg_index))
                    REG_MAX_BEFORE: max_before = cfg_data[WIN_CFG_WIDTH-1:0];
                    REG_MAX_AFTER:  max_after  = cfg_data[WIN_CFG_WIDTH-1:0];
                    REG_AVG_BEFORE: avg_before = cfg_data[WIN_CFG_WIDTH-1:0];
                    REG_AVG_AFTER:  avg_after  = cfg_data[WIN_CFG_WIDTH-1:0];
                    REG_THRESHOLD:  offset     = cfg_data[OFFSET_WIDTH-1:0];
                    REG_MIN_GAP:    min_gap    = cfg_data[GAP_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                take_sample(in_ch.sample, in_ch.end_of_stream);
            if (out_ch.valid && out_ch.ready) begin
                got.index    = out_ch.peak_index;
                got.is_peak  = out_ch.is_peak;
                got.run_last = out_ch.run_last;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result word: index %0d peak %0b last %0b",
                             $realtime, got.index, got.is_peak, got.run_last);
                end
                else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        $display({"%0t: expected index %0d peak %0b last %0b, ",
                                  "got index %0d peak %0b last %0b"},
                                 $realtime, want.index, want.is_peak, want.run_last,
                                 got.index, got.is_peak, got.run_last);
                    end
                end
            end
            mismatches <= fail_count;
            waiting    <= expected_q.size();
        end
    end

endmodule

[verif/tb.sv]
// Top of the peak picker testbench: clock, reset, register writes, sample
// streams with random gaps and result stalls, and the final verdict.
// Depends on opp_pkg, the stream interfaces, onset_peak_picker_unit and opp_peak_checker.
module tb;
    import opp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 1000000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    int                         mismatches;
    int                         waiting;
    int                         cycle_count = 0;
    int                         pace = 1;

    opp_in_if  #(.SAMPLE_WIDTH(OPP_SAMPLE_WIDTH)) in_ch();
    opp_out_if #(.INDEX_WIDTH(OPP_INDEX_WIDTH))   out_ch();

    onset_peak_picker_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    opp_peak_checker peak_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    always #1ns clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        if (pace == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_before();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return OPP_MAX_WINDOW;
        if (r == 2)
            return $urandom_range(OPP_MAX_WINDOW + 1, 63);
        return $urandom_range(1, 8);
    endfunction

    function automatic int pick_after();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return OPP_MAX_WINDOW;
        if (r == 2)
            return $urandom_range(OPP_MAX_WINDOW + 1, 63);
        if (r == 3)
            return 1;
        return $urandom_range(2, 8);
    endfunction

    task automatic configure(input int mb, input int ma, input int ab, input int aa,
                             input int th, input int gap);
        logic [CFG_DATA_WIDTH-1:0] vals[6];
        opp_reg_t                  r;
        vals[REG_MAX_BEFORE] = CFG_DATA_WIDTH'(mb);
        vals[REG_MAX_AFTER]  = CFG_DATA_WIDTH'(ma);
        vals[REG_AVG_BEFORE] = CFG_DATA_WIDTH'(ab);
        vals[REG_AVG_AFTER]  = CFG_DATA_WIDTH'(aa);
        vals[REG_THRESHOLD]  = CFG_DATA_WIDTH'(th);
        vals[REG_MIN_GAP]    = CFG_DATA_WIDTH'(gap);
        r = r.first();
        repeat (6) begin
            cfg_write <= 1'b1;
            cfg_index <= r;
            cfg_data  <= vals[int'(r)];
            @(posedge clk);
            r = r.next();
        end
        cfg_write <= 1'b0;
    endtask

    task automatic send_word(input logic signed [OPP_SAMPLE_WIDTH-1:0] s, input logic eos);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.sample        <= s;
        in_ch.end_of_stream <= eos;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic play_stream(input logic signed [OPP_SAMPLE_WIDTH-1:0] samples[$]);
        for (int n = 0; n < samples.size(); n++)
            send_word(samples[n], n == samples.size() - 1);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // result side: random stalls
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            stall = gap_len();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        logic signed [OPP_SAMPLE_WIDTH-1:0] burst[$];
        int random_items;
        int streams;
        int len;
        int style;
        int level;
        int r;
        rst_n               <= 1'b0;
        cfg_write           <= 1'b0;
        cfg_index           <= REG_MAX_BEFORE;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.sample        <= '0;
        in_ch.end_of_stream <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        burst = '{32767};
        play_stream(burst);
        burst = '{-32768, 32767, 0, 100, 100, -1, 32767, 32767, -32768, 5};
        play_stream(burst);
        configure(0, 1, 0, 1, -32768, 0);
        burst = '{3, -7, 3, 32767, -32768};
        play_stream(burst);
        configure(63, 0, 63, 0, 32767, 65535);
        burst = '{-32768, 32767, -32768, -32768, 32767};
        play_stream(burst);

        random_items = 0;
        streams = 0;
        while (random_items < 290) begin
            r = $urandom_range(0, 9);
            configure(pick_before(), pick_after(), pick_before(), pick_after(),
                      (r == 0) ? -32768 : (r == 1) ? 32767 : $urandom_range(0, 6000) - 3000,
                      (r == 2) ? 0 : (r == 3) ? 65535 : $urandom_range(1, 12));
            pace = ($urandom_range(0, 3) == 0) ? 0 : 1;
            style = $urandom_range(0, 3);
            if (streams == 2)
                len = $urandom_range(130, 170);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, 3);
            else
                len = $urandom_range(4, 48);
            burst.delete();
            level = 0;
            for (int n = 0; n < len; n++) begin
                if (style == 2)
                    level = $signed($urandom_range(0, 65535) - 32768);
                else if (style == 3)
                    level = ($urandom_range(0, 5) == 0) ? -32768 :
                            ($urandom_range(0, 4) == 0) ? 32767 : $urandom_range(0, 3) * 1000;
                else begin
                    level = level * 3 / 4 + $urandom_range(0, 600) - 100;
                    if ($urandom_range(0, 9) == 0)
                        level += $urandom_range(2000, 20000);
                    if (level > 32767)
                        level = 32767;
                    if (level < -32768)
                        level = -32768;
                end
                burst.insert(burst.size(), level[OPP_SAMPLE_WIDTH-1:0]);
            end
            play_stream(burst);
            random_items += len;
            streams++;
        end

        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/opp_pkg.sv
sv/opp_stream_if.sv
sv/opp_ctrl.sv
sv/opp_datapath.sv
sv/onset_peak_picker_unit.sv
verif/opp_peak_checker.sv
verif/tb.sv
